/* hdl/pds_pkg.sv */
// shared constants and controller/datapath interface types for the pll divider search
`default_nettype none

package pds_pkg;

  localparam int OSC_W    = 26;
  localparam int TGT_W    = 30;
  localparam int FREQ_W   = 31;
  localparam int MULT_W   = 7;
  localparam int PREDIV_W = 2;
  localparam int POST_W   = 7;
  localparam int DCLK_W   = 8;
  localparam int VCO_W    = OSC_W + MULT_W;
  localparam int CNT_W    = 6;

  localparam logic [OSC_W-1:0]  OSC_RESET = OSC_W'(24000000);
  localparam logic [MULT_W-1:0] MULT_LO   = MULT_W'(12);
  localparam logic [MULT_W-1:0] MULT_HI   = MULT_W'(99);
  localparam logic [POST_W-1:0] POST_LO   = POST_W'(6);
  localparam logic [POST_W-1:0] POST_HI   = POST_W'(127);
  // one restoring step per quotient bit
  localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(VCO_W - 1);

  typedef struct packed {
    logic start;
    logic mul;
    logic load;
    logic step;
    logic err;
    logic upd;
    logic adv;
    logic out_load;
  } pds_cmd_t;

  typedef struct packed {
    logic div_last;
    logic d_wrap;
    logic last_cand;
    logic exact;
  } pds_sts_t;

endpackage

`default_nettype wire

/* hdl/pll_divider_search.sv */
// pll divider search top level: controller and datapath
//
// Finds the PLL multiplier n (12..99), pre-divider m (1..2) and post divider
// d (6..127) whose output floor(floor(osc*n/m)/d) comes closest to twice the
// requested pixel clock; the earliest candidate wins ties, and the search
// ends at the first exact hit.
// Input transaction: in_valid/in_ready with in_target_freq. Result
// transaction: out_valid/out_ready with n, m, d, 2*d and the absolute error.
// Configuration: cfg_valid/cfg_ready with cfg_osc_freq, always ready; write
// only while no search is running.
// Each candidate passes through the load, restoring-divider, error, update
// and step states, most of its time in the divider; a new n/m pair adds a
// multiply state first. A full search covers 21472 candidates, an early exact hit fewer.
// One search runs at a time; in_ready is high only while idle.
// The result sits in an output register, so the next search may start while
// the receiver stalls; a finished search then waits until that register frees.
// Reset (synchronous, active low) returns to idle, drops out_valid and sets
// the oscillator register to 24 MHz.
`default_nettype none

module pll_divider_search
  import pds_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [OSC_W-1:0]    cfg_osc_freq,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [TGT_W-1:0]    in_target_freq,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [MULT_W-1:0]        out_pll_mult,
  output logic [PREDIV_W-1:0]      out_pll_prediv,
  output logic [POST_W-1:0]        out_post_div,
  output logic [DCLK_W-1:0]        out_dclk_div_value,
  output logic [FREQ_W-1:0]        out_freq_error
);

  pds_cmd_t cmd;
  pds_sts_t sts;

  assign cfg_ready = 1'b1;

  pds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pds_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_osc_freq       (cfg_osc_freq),
    .in_target_freq     (in_target_freq),
    .cmd                (cmd),
    .sts                (sts),
    .out_pll_mult       (out_pll_mult),
    .out_pll_prediv     (out_pll_prediv),
    .out_post_div       (out_post_div),
    .out_dclk_div_value (out_dclk_div_value),
    .out_freq_error     (out_freq_error)
  );

  // an accepted search leaves the block busy, so in_ready drops
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_prediv_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pll_prediv == 2'd1) || (out_pll_prediv == 2'd2))
    else $error("pre-divider out of range");

  a_dclk_twice_post: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dclk_div_value == {out_post_div, 1'b0})
    else $error("divider register value not twice the post divider");

  a_mult_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pll_mult >= MULT_LO) && (out_pll_mult <= MULT_HI)
      && (out_post_div >= POST_LO))
    else $error("multiplier or post divider out of range");

endmodule

`default_nettype wire

/* hdl/pds_dp.sv */
// datapath: oscillator register, candidate counters, multiplier, serial divider, best tracker
`default_nettype none

module pds_dp
  import pds_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [OSC_W-1:0]    cfg_osc_freq,
  input  wire logic [TGT_W-1:0]    in_target_freq,
  input  wire pds_cmd_t            cmd,
  output pds_sts_t                 sts,
  output logic [MULT_W-1:0]        out_pll_mult,
  output logic [PREDIV_W-1:0]      out_pll_prediv,
  output logic [POST_W-1:0]        out_post_div,
  output logic [DCLK_W-1:0]        out_dclk_div_value,
  output logic [FREQ_W-1:0]        out_freq_error
);

  logic [OSC_W-1:0]  osc_r;
  logic [FREQ_W-1:0] goal_r;
  logic [MULT_W-1:0] n_r;
  logic              m_r;
  logic [POST_W-1:0] d_r;
  logic [VCO_W-1:0]  vco_r;
  logic [VCO_W-1:0]  div_r;
  logic [POST_W-1:0] rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [FREQ_W-1:0] err_r;
  logic              best_vld_r;
  logic [FREQ_W-1:0] min_err_r;
  logic [MULT_W-1:0] best_n_r;
  logic              best_m_r;
  logic [POST_W-1:0] best_d_r;

  logic [VCO_W-1:0]  prod;
  logic [POST_W:0]   trial;
  logic              ge;
  logic [POST_W:0]   trial_sub;
  logic [FREQ_W-1:0] quo;

  // 26x7 product; vco_r takes it halved when the pre-divider is two
  assign prod = VCO_W'(osc_r) * VCO_W'(n_r);

  assign trial     = {rem_r, div_r[VCO_W-1]};
  assign ge        = trial >= {1'b0, d_r};
  assign trial_sub = trial - {1'b0, d_r};
  assign quo       = div_r[FREQ_W-1:0];

  assign sts.div_last  = cnt_r == DIV_LAST;
  assign sts.d_wrap    = d_r == POST_HI;
  assign sts.last_cand = (n_r == MULT_HI) && m_r && (d_r == POST_HI);
  assign sts.exact     = best_vld_r && (min_err_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osc_r <= OSC_RESET;
    end else if (cfg_we) begin
      osc_r <= cfg_osc_freq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_vld_r <= 1'b0;
    end else if (cmd.start) begin
      best_vld_r <= 1'b0;
    end else if (cmd.upd) begin
      best_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      goal_r <= {in_target_freq, 1'b0};
      n_r    <= MULT_LO;
      m_r    <= 1'b0;
      d_r    <= POST_LO;
    end else if (cmd.adv) begin
      if (d_r == POST_HI) begin
        d_r <= POST_LO;
        m_r <= ~m_r;
        if (m_r) begin
          n_r <= n_r + MULT_W'(1);
        end
      end else begin
        d_r <= d_r + POST_W'(1);
      end
    end

    if (cmd.mul) begin
      vco_r <= m_r ? (prod >> 1) : prod;
    end

    if (cmd.load) begin
      div_r <= vco_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.step) begin
      div_r <= {div_r[VCO_W-2:0], ge};
      rem_r <= ge ? trial_sub[POST_W-1:0] : trial[POST_W-1:0];
      cnt_r <= cnt_r + CNT_W'(1);
    end

    // quotient is below 2^31 for every legal divider
    if (cmd.err) begin
      err_r <= (quo >= goal_r) ? (quo - goal_r) : (goal_r - quo);
    end

    if (cmd.upd && (!best_vld_r || (err_r < min_err_r))) begin
      min_err_r <= err_r;
      best_n_r  <= n_r;
      best_m_r  <= m_r;
      best_d_r  <= d_r;
    end

    if (cmd.out_load) begin
      out_pll_mult       <= best_n_r;
      out_pll_prediv     <= {best_m_r, ~best_m_r};
      out_post_div       <= best_d_r;
      out_dclk_div_value <= {best_d_r, 1'b0};
      out_freq_error     <= min_err_r;
    end
  end

endmodule

`default_nettype wire

/* hdl/pds_ctrl.sv */
// controller: sequences the candidate search and owns the input and result handshakes
`default_nettype none

module pds_ctrl
  import pds_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire pds_sts_t sts,
  output pds_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_ERR  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_STEP = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        cmd.err   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        // stop on an exact hit or after the last candidate
        if (sts.exact || sts.last_cand) begin
          state_nxt = S_OUT;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = sts.d_wrap ? S_MUL : S_LOAD;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb_pll_divider_search.sv */
// testbench for the pll divider search: directed and random searches checked against a predictor
module tb_pll_divider_search
  import pds_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 100_000_000;
  localparam int unsigned HOLD_CYCLES = 4000;
  // searches that end this early keep the random part short
  localparam int unsigned CHEAP_TRIALS = 300;
  localparam int PREDIV_LO = 1;
  localparam int PREDIV_HI = 2;
  localparam logic [OSC_W-1:0] OSC_RANGE_LO = OSC_W'(1_000_000);
  localparam logic [OSC_W-1:0] OSC_RANGE_HI = OSC_W'(43_000_000);

  typedef struct packed {
    logic [MULT_W-1:0]   mult;
    logic [PREDIV_W-1:0] prediv;
    logic [POST_W-1:0]   post;
    logic [DCLK_W-1:0]   dclk;
    logic [FREQ_W-1:0]   err;
  } pll_choice_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [OSC_W-1:0] cfg_osc_freq = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [TGT_W-1:0] in_target_freq = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [MULT_W-1:0] out_pll_mult;
  logic [PREDIV_W-1:0] out_pll_prediv;
  logic [POST_W-1:0] out_post_div;
  logic [DCLK_W-1:0] out_dclk_div_value;
  logic [FREQ_W-1:0] out_freq_error;

  logic [OSC_W-1:0] osc_model = OSC_RESET;
  pll_choice_t expected_choices[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit no_idle = 1'b0;
  bit hold_out = 1'b0;

  pll_divider_search i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_osc_freq       (cfg_osc_freq),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_target_freq     (in_target_freq),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pll_mult       (out_pll_mult),
    .out_pll_prediv     (out_pll_prediv),
    .out_post_div       (out_post_div),
    .out_dclk_div_value (out_dclk_div_value),
    .out_freq_error     (out_freq_error)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // full search in n, m, d order; stops at the first exact hit
  function automatic pll_choice_t best_divider(input logic [OSC_W-1:0] osc,
                                               input logic [TGT_W-1:0] tgt,
                                               output int unsigned trials);
    bit [63:0] goal;
    bit [63:0] low_err;
    bit [63:0] vco;
    bit [63:0] achieved;
    bit [63:0] diff;
    int n;
    int m;
    int d;
    int bn;
    int bm;
    int bd;
    bit hit;
    pll_choice_t r;
    goal = 64'(tgt) * 64'd2;
    low_err = 64'hffff_ffff;
    bn = MULT_LO;
    bm = PREDIV_LO;
    bd = POST_LO;
    hit = 1'b0;
    trials = 0;
    for (n = MULT_LO; n <= MULT_HI && !hit; n++) begin
      for (m = PREDIV_LO; m <= PREDIV_HI && !hit; m++) begin
        vco = (64'(osc) * 64'(n)) / 64'(m);
        for (d = POST_LO; d <= POST_HI && !hit; d++) begin
          trials++;
          achieved = vco / 64'(d);
          diff = (achieved >= goal) ? achieved - goal : goal - achieved;
          if (diff < low_err) begin
            low_err = diff;
            bn = n;
            bm = m;
            bd = d;
            hit = (diff == 0);
          end
        end
      end
    end
    r.mult = MULT_W'(bn);
    r.prediv = PREDIV_W'(bm);
    r.post = POST_W'(bd);
    r.dclk = DCLK_W'(2 * bd);
    r.err = FREQ_W'(low_err);
    return r;
  endfunction

  // target that some low-n candidate hits exactly, so the search ends early
  function automatic logic [TGT_W-1:0] exact_target(input logic [OSC_W-1:0] osc);
    bit [63:0] f;
    int unsigned trials;
    logic [TGT_W-1:0] t;
    while (1) begin
      f = (64'(osc) * 64'($urandom_range(13, MULT_LO))) / 64'($urandom_range(PREDIV_HI, PREDIV_LO));
      f = f / 64'($urandom_range(POST_HI, POST_LO));
      if (!f[0]) begin
        t = TGT_W'(f >> 1);
        void'(best_divider(osc, t, trials));
        if (trials <= CHEAP_TRIALS) return t;
      end
    end
  endfunction

  task automatic send_target(input logic [TGT_W-1:0] tgt);
    pll_choice_t want;
    int unsigned trials;
    want = best_divider(osc_model, tgt, trials);
    if (!no_idle && $urandom_range(99, 0) < 21) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_target_freq <= tgt;
    do @(posedge clk); while (!in_ready);
    expected_choices.push_back(want);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_choices.size() != 0) @(posedge clk);
  endtask

  task automatic write_osc(input logic [OSC_W-1:0] osc);
    cfg_valid <= 1'b1;
    cfg_osc_freq <= osc;
    do @(posedge clk); while (!cfg_ready);
    osc_model = osc;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_oscillator();
    // first candidate exact, a tie between (12,1,12) and (12,2,6), and a hit at n=13
    send_target(TGT_W'(24_000_000));
    send_target(TGT_W'(12_000_000));
    send_target(TGT_W'(614_173));
    send_target(exact_target(osc_model));
    send_target(exact_target(osc_model));
    wait_drained();
  endtask

  task automatic test_zero_oscillator();
    // every candidate gives 0; a nonzero target runs the whole search
    write_osc('0);
    send_target('0);
    send_target('1);
    wait_drained();
  endtask

  task automatic test_wide_oscillator();
    // products beyond 32 bits; the smallest target never hits and searches everything
    write_osc('1);
    send_target(exact_target(osc_model));
    send_target(TGT_W'(1));
    send_target(exact_target(osc_model));
    wait_drained();
  endtask

  task automatic test_range_ends();
    write_osc(OSC_RANGE_LO);
    send_target(TGT_W'(osc_model));
    send_target(exact_target(osc_model));
    send_target(exact_target(osc_model));
    wait_drained();
    write_osc(OSC_RANGE_HI);
    send_target(TGT_W'(osc_model));
    send_target(exact_target(osc_model));
    send_target(exact_target(osc_model));
    wait_drained();
  endtask

  task automatic test_output_stall();
    // short searches pile up behind a stalled receiver until in_ready drops
    hold_out = 1'b1;
    repeat (4) send_target(TGT_W'(osc_model));
    wait_drained();
  endtask

  task automatic test_random_search();
    int p;
    int i;
    logic [TGT_W-1:0] tgt;
    for (p = 0; p < 5; p++) begin
      write_osc(($urandom_range(3, 0) == 0) ? OSC_W'($urandom)
                                            : OSC_W'($urandom_range(OSC_RANGE_HI, OSC_RANGE_LO)));
      no_idle = (p == 1);
      for (i = 0; i < 16; i++) begin
        if (p == 3 && i == 0) begin
          tgt = TGT_W'($urandom);
        end else if (i > 0 && $urandom_range(99, 0) < 12) begin
          // same target again
        end else begin
          tgt = exact_target(osc_model);
        end
        send_target(tgt);
      end
      wait_drained();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99, 0) >= 21);
      end
    end
  end

  always @(posedge clk) begin
    pll_choice_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_choices.size() == 0) begin
        $display("%0t: result transaction with nothing expected, mult %0d prediv %0d post %0d",
                 $time, out_pll_mult, out_pll_prediv, out_post_div);
        mismatches++;
      end else begin
        want = expected_choices.pop_front();
        if (out_pll_mult !== want.mult) begin
          $display("%0t: pll_mult expected %0d actual %0d", $time, want.mult, out_pll_mult);
          mismatches++;
        end
        if (out_pll_prediv !== want.prediv) begin
          $display("%0t: pll_prediv expected %0d actual %0d", $time, want.prediv,
                   out_pll_prediv);
          mismatches++;
        end
        if (out_post_div !== want.post) begin
          $display("%0t: post_div expected %0d actual %0d", $time, want.post, out_post_div);
          mismatches++;
        end
        if (out_dclk_div_value !== want.dclk) begin
          $display("%0t: dclk_div_value expected %0d actual %0d", $time, want.dclk,
                   out_dclk_div_value);
          mismatches++;
        end
        if (out_freq_error !== want.err) begin
          $display("%0t: freq_error expected %0d actual %0d", $time, want.err, out_freq_error);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_oscillator();
    test_zero_oscillator();
    test_wide_oscillator();
    test_range_ends();
    test_output_stall();
    test_random_search();
    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_choices.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
